// File: rtl/sbe_pkg.sv
// Shared types and constants for the stack bytecode executor.
// Every RTL file of the block refers to this package by scoped names.
package sbe_pkg;

   // Storage sizes.
   localparam int STACK_DEPTH  = 2048;
   localparam int LOCAL_COUNT  = 256;
   localparam int GLOBAL_COUNT = 1024;

   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int LOCAL_AW    = $clog2(LOCAL_COUNT);
   localparam int GLOBAL_AW   = $clog2(GLOBAL_COUNT);
   localparam int CLEAR_COUNT = (LOCAL_COUNT > GLOBAL_COUNT) ? LOCAL_COUNT : GLOBAL_COUNT;
   localparam int CLEAR_AW    = $clog2(CLEAR_COUNT);

   // Field widths fixed by the interface.
   localparam int DEPTH_W       = 12;
   localparam int LOCAL_FIELD_W = 8;

   // Queues between the parts; depths are powers of two so pointers wrap.
   localparam int INSN_QUEUE_DEPTH = 2;
   localparam int INSN_QUEUE_AW    = $clog2(INSN_QUEUE_DEPTH);
   localparam int RSP_QUEUE_DEPTH  = 2;
   localparam int RSP_QUEUE_AW     = $clog2(RSP_QUEUE_DEPTH);

   // Divider.
   localparam int DIV_STEPS  = 32;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   localparam logic [31:0] LIMIT_RESET = 32'd1000000;

   // Opcodes.
   localparam logic [7:0] OP_NOP          = 8'h00;
   localparam logic [7:0] OP_HALT         = 8'h01;
   localparam logic [7:0] OP_PUSH_A       = 8'h10;
   localparam logic [7:0] OP_PUSH_B       = 8'h11;
   localparam logic [7:0] OP_ADD          = 8'h20;
   localparam logic [7:0] OP_SUB          = 8'h21;
   localparam logic [7:0] OP_MUL          = 8'h22;
   localparam logic [7:0] OP_DIV          = 8'h23;
   localparam logic [7:0] OP_LOAD_LOCAL   = 8'h30;
   localparam logic [7:0] OP_STORE_LOCAL  = 8'h31;
   localparam logic [7:0] OP_LOAD_GLOBAL  = 8'h32;
   localparam logic [7:0] OP_STORE_GLOBAL = 8'h33;

   // Status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_OVER    = 3'd2;
   localparam logic [2:0] ST_UNDER   = 3'd3;
   localparam logic [2:0] ST_DIVZ    = 3'd4;
   localparam logic [2:0] ST_UNKNOWN = 3'd5;
   localparam logic [2:0] ST_STOPPED = 3'd6;
   localparam logic [2:0] ST_LIMIT   = 3'd7;

   typedef enum logic [3:0] {
      CLS_NOP,
      CLS_HALT,
      CLS_PUSH,
      CLS_ADD,
      CLS_SUB,
      CLS_MUL,
      CLS_DIV,
      CLS_LOAD_LOCAL,
      CLS_STORE_LOCAL,
      CLS_LOAD_GLOBAL,
      CLS_STORE_GLOBAL,
      CLS_UNKNOWN
   } sbe_class_type;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [31:0] constant_word;
      logic [15:0] slot_index;
      logic        code_ended;
   } sbe_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        halt_value;
      logic [DEPTH_W-1:0] stack_depth;
   } sbe_rsp_type;

   typedef struct packed {
      sbe_class_type op_class;
      logic [31:0]   constant_word;
      logic [15:0]   slot_index;
      logic          slot_ok;
      logic          code_ended;
   } sbe_insn_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } sbe_div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } sbe_div_rsp_type;

endpackage

// File: rtl/sbe_front.sv
// Front end of the executor: accepts request beats, classifies the opcode
// and holds decoded instructions in a short queue. Uses sbe_pkg.
module sbe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept_en,
   input  logic                  push,
   output logic                  full,
   input  sbe_pkg::sbe_req_type  req_data,
   output logic                  insn_valid,
   output sbe_pkg::sbe_insn_type insn,
   input  logic                  insn_take
);

   function automatic sbe_pkg::sbe_insn_type classify(sbe_pkg::sbe_req_type r);
      sbe_pkg::sbe_insn_type d;
      d.constant_word = r.constant_word;
      d.slot_index    = r.slot_index;
      d.code_ended    = r.code_ended;
      d.slot_ok       = 1'b1;
      unique case (r.opcode) inside
         sbe_pkg::OP_NOP:  d.op_class = sbe_pkg::CLS_NOP;
         sbe_pkg::OP_HALT: d.op_class = sbe_pkg::CLS_HALT;
         sbe_pkg::OP_PUSH_A, sbe_pkg::OP_PUSH_B: d.op_class = sbe_pkg::CLS_PUSH;
         sbe_pkg::OP_ADD:  d.op_class = sbe_pkg::CLS_ADD;
         sbe_pkg::OP_SUB:  d.op_class = sbe_pkg::CLS_SUB;
         sbe_pkg::OP_MUL:  d.op_class = sbe_pkg::CLS_MUL;
         sbe_pkg::OP_DIV:  d.op_class = sbe_pkg::CLS_DIV;
         sbe_pkg::OP_LOAD_LOCAL, sbe_pkg::OP_STORE_LOCAL: begin
            d.op_class = (r.opcode == sbe_pkg::OP_LOAD_LOCAL) ?
                         sbe_pkg::CLS_LOAD_LOCAL : sbe_pkg::CLS_STORE_LOCAL;
            d.slot_ok  = 32'(r.slot_index[sbe_pkg::LOCAL_FIELD_W-1:0]) <
                         sbe_pkg::LOCAL_COUNT;
         end
         sbe_pkg::OP_LOAD_GLOBAL, sbe_pkg::OP_STORE_GLOBAL: begin
            d.op_class = (r.opcode == sbe_pkg::OP_LOAD_GLOBAL) ?
                         sbe_pkg::CLS_LOAD_GLOBAL : sbe_pkg::CLS_STORE_GLOBAL;
            d.slot_ok  = 32'(r.slot_index) < sbe_pkg::GLOBAL_COUNT;
         end
         default: d.op_class = sbe_pkg::CLS_UNKNOWN;
      endcase
      return d;
   endfunction

   sbe_pkg::sbe_insn_type               q_ff [sbe_pkg::INSN_QUEUE_DEPTH];
   logic [sbe_pkg::INSN_QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sbe_pkg::INSN_QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sbe_pkg::INSN_QUEUE_AW:0]     count_ff, count_in;
   logic                                do_push, do_pop;

   assign full       = !accept_en ||
                       (count_ff == (sbe_pkg::INSN_QUEUE_AW + 1)'(sbe_pkg::INSN_QUEUE_DEPTH));
   assign do_push    = push && !full;
   assign insn_valid = count_ff != '0;
   assign do_pop     = insn_take && insn_valid;
   assign insn       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= classify(req_data);
      end
   end

endmodule

// File: rtl/sbe_div.sv
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Uses the request and response structs of sbe_pkg.
module sbe_div (
   input  logic                     clock,
   input  logic                     reset,
   input  sbe_pkg::sbe_div_req_type div_req,
   output sbe_pkg::sbe_div_rsp_type div_rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sbe_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic [31:0]                    rem_ff, rem_in;
   logic [31:0]                    quo_ff, quo_in;
   logic [31:0]                    divisor_ff, divisor_in;
   logic [32:0]                    shifted;
   logic [32:0]                    diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // Restoring step: the dividend shifts out of quo_ff as quotient bits shift in.
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == sbe_pkg::DIV_STEP_W'(sbe_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: rtl/sbe_back.sv
// Back end of the executor: runs decoded instructions against the operand
// stack, local and global memories. Uses sbe_pkg and the sbe_div unit.
module sbe_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [31:0]               csr_wr_data,
   input  logic                      insn_valid,
   input  sbe_pkg::sbe_insn_type     insn,
   output logic                      insn_take,
   input  logic                      rsp_space,
   output logic                      res_valid,
   output sbe_pkg::sbe_rsp_type      result,
   output logic                      clearing,
   output sbe_pkg::sbe_div_req_type  div_req,
   input  sbe_pkg::sbe_div_rsp_type  div_rsp
);

   typedef enum logic [3:0] {
      S_CLEAR    = 4'b0001,
      S_DISPATCH = 4'b0010,
      S_EXEC     = 4'b0100,
      S_DIVIDE   = 4'b1000
   } sbe_state_type;

   localparam int CW = sbe_pkg::COUNT_W;
   localparam int SW = sbe_pkg::STACK_AW;

   sbe_state_type               state_ff, state_in;
   logic [CW-1:0]               stack_count_ff, stack_count_in;
   logic                        running_ff, running_in;
   logic [31:0]                 executed_ff, executed_in;
   logic [31:0]                 limit_ff;
   logic [sbe_pkg::CLEAR_AW-1:0] clr_addr_ff, clr_addr_in;
   sbe_pkg::sbe_insn_type       cur_ff, cur_in;
   logic                        under_ff, under_in;

   logic [31:0] stack_mem_ff  [sbe_pkg::STACK_DEPTH];
   logic [31:0] local_mem_ff  [sbe_pkg::LOCAL_COUNT];
   logic [31:0] global_mem_ff [sbe_pkg::GLOBAL_COUNT];
   logic [31:0] rd_top_ff, rd_next_ff, local_rd_ff, global_rd_ff;

   logic                          stk_we;
   logic [SW-1:0]                 stk_waddr;
   logic [31:0]                   stk_wdata;
   logic                          loc_we;
   logic [sbe_pkg::LOCAL_AW-1:0]  loc_waddr;
   logic [31:0]                   loc_wdata;
   logic                          glob_we;
   logic [sbe_pkg::GLOBAL_AW-1:0] glob_waddr;
   logic [31:0]                   glob_wdata;

   logic [SW-1:0] top_addr, next_addr;
   logic          pop_two, under;
   logic [31:0]   opnd_a, opnd_b;
   logic [CW-1:0] count_popped;
   logic          has_room;

   assign top_addr  = SW'(stack_count_ff - CW'(1));
   assign next_addr = SW'(stack_count_ff - CW'(2));
   assign clearing  = state_ff == S_CLEAR;
   assign has_room  = stack_count_ff < CW'(sbe_pkg::STACK_DEPTH);

   // A pop from an empty stack reads as zero.
   always_comb begin
      pop_two = (cur_ff.op_class == sbe_pkg::CLS_ADD) || (cur_ff.op_class == sbe_pkg::CLS_SUB) ||
                (cur_ff.op_class == sbe_pkg::CLS_MUL) || (cur_ff.op_class == sbe_pkg::CLS_DIV);
      opnd_b  = (stack_count_ff != '0) ? rd_top_ff : '0;
      opnd_a  = (stack_count_ff >= CW'(2)) ? rd_next_ff : '0;
      if (pop_two) begin
         under        = stack_count_ff < CW'(2);
         count_popped = under ? '0 : stack_count_ff - CW'(2);
      end else begin
         under        = stack_count_ff == '0;
         count_popped = under ? '0 : stack_count_ff - CW'(1);
      end
   end

   always_comb begin
      logic [2:0]  st;
      logic [31:0] hv;
      logic        fin;
      st             = sbe_pkg::ST_OK;
      hv             = '0;
      fin            = 1'b0;
      state_in       = state_ff;
      stack_count_in = stack_count_ff;
      running_in     = running_ff;
      executed_in    = executed_ff;
      clr_addr_in    = clr_addr_ff;
      cur_in         = cur_ff;
      under_in       = under_ff;
      insn_take      = 1'b0;
      stk_we         = 1'b0;
      stk_waddr      = stack_count_ff[SW-1:0];
      stk_wdata      = cur_ff.constant_word;
      loc_we         = 1'b0;
      loc_waddr      = cur_ff.slot_index[sbe_pkg::LOCAL_AW-1:0];
      loc_wdata      = opnd_b;
      glob_we        = 1'b0;
      glob_waddr     = cur_ff.slot_index[sbe_pkg::GLOBAL_AW-1:0];
      glob_wdata     = opnd_b;
      div_req        = '0;

      unique case (state_ff)
         S_CLEAR: begin
            loc_we     = 32'(clr_addr_ff) < sbe_pkg::LOCAL_COUNT;
            loc_waddr  = clr_addr_ff[sbe_pkg::LOCAL_AW-1:0];
            loc_wdata  = '0;
            glob_we    = 32'(clr_addr_ff) < sbe_pkg::GLOBAL_COUNT;
            glob_waddr = clr_addr_ff[sbe_pkg::GLOBAL_AW-1:0];
            glob_wdata = '0;
            if (clr_addr_ff == sbe_pkg::CLEAR_AW'(sbe_pkg::CLEAR_COUNT - 1)) begin
               state_in = S_DISPATCH;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_DISPATCH: begin
            if (insn_valid && rsp_space) begin
               insn_take = 1'b1;
               cur_in    = insn;
               if (!running_ff) begin
                  st  = sbe_pkg::ST_STOPPED;
                  fin = 1'b1;
               end else if (executed_ff >= limit_ff) begin
                  st  = sbe_pkg::ST_LIMIT;
                  fin = 1'b1;
               end else if (insn.code_ended) begin
                  running_in = 1'b0;
                  st         = sbe_pkg::ST_STOPPED;
                  fin        = 1'b1;
               end else begin
                  executed_in = executed_ff + 32'd1;
                  unique case (insn.op_class) inside
                     sbe_pkg::CLS_NOP: begin
                        fin = 1'b1;
                     end
                     sbe_pkg::CLS_PUSH: begin
                        fin = 1'b1;
                        if (has_room) begin
                           stk_we         = 1'b1;
                           stk_wdata      = insn.constant_word;
                           stack_count_in = stack_count_ff + CW'(1);
                        end else begin
                           running_in = 1'b0;
                           st         = sbe_pkg::ST_OVER;
                        end
                     end
                     sbe_pkg::CLS_LOAD_LOCAL, sbe_pkg::CLS_STORE_LOCAL,
                     sbe_pkg::CLS_LOAD_GLOBAL, sbe_pkg::CLS_STORE_GLOBAL: begin
                        // An out-of-range slot is a counted no-op.
                        if (insn.slot_ok) begin
                           state_in = S_EXEC;
                        end else begin
                           fin = 1'b1;
                        end
                     end
                     sbe_pkg::CLS_HALT, sbe_pkg::CLS_ADD, sbe_pkg::CLS_SUB,
                     sbe_pkg::CLS_MUL, sbe_pkg::CLS_DIV: begin
                        state_in = S_EXEC;
                     end
                     default: begin
                        running_in = 1'b0;
                        st         = sbe_pkg::ST_UNKNOWN;
                        fin        = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_EXEC: begin
            fin = 1'b1;
            unique case (cur_ff.op_class) inside
               sbe_pkg::CLS_HALT: begin
                  stack_count_in = count_popped;
                  running_in     = 1'b0;
                  st             = under ? sbe_pkg::ST_UNDER : sbe_pkg::ST_HALT;
                  hv             = opnd_b;
               end
               sbe_pkg::CLS_STORE_LOCAL, sbe_pkg::CLS_STORE_GLOBAL: begin
                  loc_we         = cur_ff.op_class == sbe_pkg::CLS_STORE_LOCAL;
                  glob_we        = cur_ff.op_class == sbe_pkg::CLS_STORE_GLOBAL;
                  stack_count_in = count_popped;
                  if (under) begin
                     running_in = 1'b0;
                     st         = sbe_pkg::ST_UNDER;
                  end
               end
               sbe_pkg::CLS_LOAD_LOCAL, sbe_pkg::CLS_LOAD_GLOBAL: begin
                  stk_wdata = (cur_ff.op_class == sbe_pkg::CLS_LOAD_LOCAL) ?
                              local_rd_ff : global_rd_ff;
                  if (has_room) begin
                     stk_we         = 1'b1;
                     stack_count_in = stack_count_ff + CW'(1);
                  end else begin
                     running_in = 1'b0;
                     st         = sbe_pkg::ST_OVER;
                  end
               end
               sbe_pkg::CLS_ADD, sbe_pkg::CLS_SUB, sbe_pkg::CLS_MUL: begin
                  // Two pops always leave room for the push.
                  stk_we    = 1'b1;
                  stk_waddr = count_popped[SW-1:0];
                  if (cur_ff.op_class == sbe_pkg::CLS_ADD) begin
                     stk_wdata = opnd_a + opnd_b;
                  end else if (cur_ff.op_class == sbe_pkg::CLS_SUB) begin
                     stk_wdata = opnd_a - opnd_b;
                  end else begin
                     stk_wdata = opnd_a * opnd_b;
                  end
                  stack_count_in = count_popped + CW'(1);
                  if (under) begin
                     running_in = 1'b0;
                     st         = sbe_pkg::ST_UNDER;
                  end
               end
               sbe_pkg::CLS_DIV: begin
                  stack_count_in = count_popped;
                  under_in       = under;
                  if (under) begin
                     running_in = 1'b0;
                  end
                  if (opnd_b == '0) begin
                     running_in = 1'b0;
                     st         = under ? sbe_pkg::ST_UNDER : sbe_pkg::ST_DIVZ;
                  end else begin
                     fin              = 1'b0;
                     div_req.start    = 1'b1;
                     div_req.dividend = opnd_a;
                     div_req.divisor  = opnd_b;
                     state_in         = S_DIVIDE;
                  end
               end
               default: begin
                  st = sbe_pkg::ST_OK;
               end
            endcase
            if (fin) begin
               state_in = S_DISPATCH;
            end
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               stk_we         = 1'b1;
               stk_wdata      = div_rsp.quotient;
               stack_count_in = stack_count_ff + CW'(1);
               st             = under_ff ? sbe_pkg::ST_UNDER : sbe_pkg::ST_OK;
               fin            = 1'b1;
               state_in       = S_DISPATCH;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      res_valid          = fin;
      result.status      = st;
      result.halt_value  = hv;
      result.stack_depth = sbe_pkg::DEPTH_W'(stack_count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         stack_count_ff <= '0;
         running_ff     <= 1'b1;
         executed_ff    <= '0;
         limit_ff       <= sbe_pkg::LIMIT_RESET;
         clr_addr_ff    <= '0;
         under_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stack_count_ff <= stack_count_in;
         running_ff     <= running_in;
         executed_ff    <= executed_in;
         clr_addr_ff    <= clr_addr_in;
         under_ff       <= under_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Operands and slot data are fetched while dispatching, used in S_EXEC.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem_ff[stk_waddr] <= stk_wdata;
      end
      if (state_ff == S_DISPATCH) begin
         rd_top_ff  <= stack_mem_ff[top_addr];
         rd_next_ff <= stack_mem_ff[next_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (loc_we) begin
         local_mem_ff[loc_waddr] <= loc_wdata;
      end
      if (state_ff == S_DISPATCH) begin
         local_rd_ff <= local_mem_ff[insn.slot_index[sbe_pkg::LOCAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (glob_we) begin
         global_mem_ff[glob_waddr] <= glob_wdata;
      end
      if (state_ff == S_DISPATCH) begin
         global_rd_ff <= global_mem_ff[insn.slot_index[sbe_pkg::GLOBAL_AW-1:0]];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= CW'(sbe_pkg::STACK_DEPTH))
      else $error("operand stack count above its depth");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      !running_ff |=> !running_ff)
      else $error("execution resumed after a stop");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !res_valid && !insn_take)
      else $error("instruction handled during the clearing pass");

   a_result_space: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> rsp_space)
      else $error("result written with no room in the result queue");

   a_exec_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (executed_ff == $past(executed_ff)) ||
               (executed_ff == $past(executed_ff) + 32'd1))
      else $error("instruction counter moved by more than one");

endmodule

// File: rtl/stack_bytecode_executor_core.sv
// Flow: push, nop, out-of-range slot and status-only items finish in S_DISPATCH; pops,
// loads and stores also pass through S_EXEC, and a divide that runs the divider passes
// through S_EXEC and then waits in S_DIVIDE until the divider is done.
// Throughput: one item per cycle for push, nop and status-only items while the result queue
// has room; no new item is taken until a stack pop, load, store or divide (32-step bit-serial divider) has finished.
// After reset, full stays high while the local and global memories clear.
module stack_bytecode_executor_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  sbe_pkg::sbe_req_type req_data,
   output logic                 empty,
   input  logic                 pop,
   output sbe_pkg::sbe_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data
);

   logic                     insn_valid;
   sbe_pkg::sbe_insn_type    insn;
   logic                     insn_take;
   logic                     rsp_space;
   logic                     res_valid;
   sbe_pkg::sbe_rsp_type     result;
   logic                     clearing;
   sbe_pkg::sbe_div_req_type div_req;
   sbe_pkg::sbe_div_rsp_type div_rsp;

   sbe_pkg::sbe_rsp_type             rq_ff [sbe_pkg::RSP_QUEUE_DEPTH];
   logic [sbe_pkg::RSP_QUEUE_AW-1:0] rq_wr_ff, rq_wr_in;
   logic [sbe_pkg::RSP_QUEUE_AW-1:0] rq_rd_ff, rq_rd_in;
   logic [sbe_pkg::RSP_QUEUE_AW:0]   rq_count_ff, rq_count_in;
   logic                             rq_pop;

   sbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_en  (!clearing),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .insn_valid (insn_valid),
      .insn       (insn),
      .insn_take  (insn_take)
   );

   sbe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   sbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .insn_valid  (insn_valid),
      .insn        (insn),
      .insn_take   (insn_take),
      .rsp_space   (rsp_space),
      .res_valid   (res_valid),
      .result      (result),
      .clearing    (clearing),
      .div_req     (div_req),
      .div_rsp     (div_rsp)
   );

   // Result queue: the executor only dispatches with a free slot, so a
   // result beat is never dropped.
   assign rsp_space = rq_count_ff != (sbe_pkg::RSP_QUEUE_AW + 1)'(sbe_pkg::RSP_QUEUE_DEPTH);
   assign empty     = rq_count_ff == '0;
   assign rq_pop    = pop && !empty;
   assign rsp_data  = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in    = res_valid ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in    = rq_pop ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_count_in = rq_count_ff;
      if (res_valid && !rq_pop) begin
         rq_count_in = rq_count_ff + 1'b1;
      end else if (rq_pop && !res_valid) begin
         rq_count_in = rq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rq_ff[rq_wr_ff] <= result;
      end
   end

endmodule
